// ===== design/rgba_layer_blend_canvas_defines.svh =====
// Assertion macros for the RGBA layer blend canvas.
`ifndef RGBA_LAYER_BLEND_CANVAS_DEFINES_SVH
`define RGBA_LAYER_BLEND_CANVAS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define RLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define RLB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RLB_ASSERT(lbl, prop, msg)
`define RLB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/rlb_pkg.sv =====
// Shared types, constants and a helper function of the RGBA layer blend canvas.
`timescale 1ns / 1ps
`default_nettype none
package rlb_pkg;

  localparam int DefaultWidth  = 1280;
  localparam int DefaultHeight = 720;
  localparam logic [31:0] BgReset = 32'h0000_00FF;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_BLEND = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADDR,
    ST_MIX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pix_t;

  // floor(x / 255) for x up to 255 * 255, by shift and add.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
    return t[15:8];
  endfunction

endpackage
`default_nettype wire

// ===== design/rlb_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module rlb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/rlb_blend.sv =====
// Over-rule datapath: registered channel sums, then division by 255.
`timescale 1ns / 1ps
`default_nettype none
module rlb_blend (
  input  wire logic          clk_i,
  input  wire logic          load_i,
  input  wire rlb_pkg::pix_t src_i,
  input  wire rlb_pkg::pix_t old_i,
  input  wire logic [7:0]    e_i,
  output rlb_pkg::pix_t      mix_o
);

  logic [7:0]  inv_e;
  logic [15:0] sum_r_q, sum_g_q, sum_b_q, prod_a_q;
  logic [7:0]  alpha_add;
  logic [8:0]  alpha_sum;

  assign inv_e = 8'd255 - e_i;

  // Capture the weighted sums while the old pixel is on the RAM read port.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_r_q  <= {8'b0, src_i.r} * {8'b0, e_i} + {8'b0, old_i.r} * {8'b0, inv_e};
      sum_g_q  <= {8'b0, src_i.g} * {8'b0, e_i} + {8'b0, old_i.g} * {8'b0, inv_e};
      sum_b_q  <= {8'b0, src_i.b} * {8'b0, e_i} + {8'b0, old_i.b} * {8'b0, inv_e};
      prod_a_q <= {8'b0, old_i.a} * {8'b0, inv_e};
    end
  end

  assign alpha_add = rlb_pkg::div255(prod_a_q);
  assign alpha_sum = {1'b0, e_i} + {1'b0, alpha_add};

  always_comb begin
    mix_o.r = rlb_pkg::div255(sum_r_q);
    mix_o.g = rlb_pkg::div255(sum_g_q);
    mix_o.b = rlb_pkg::div255(sum_b_q);
    mix_o.a = alpha_sum[7:0];
  end

endmodule
`default_nettype wire

// ===== design/rgba_layer_blend_canvas.sv =====
// Top level of the RGBA layer blend canvas: control, address, result register.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-------------------------------
//   cfg      | in        | cfg_valid_i / cfg_ready_o  | fill_color_i
//   in       | in        | in_valid_i  / in_stall_o   | req_type_i, pos, src, layer
//   out      | out       | out_valid_o / out_stall_i  | pix_*_o, clipped_o, skipped_o
//
// One beat is in flight at a time. Blend and read beats pass through the idle,
// address, mix and done steps before the next acceptance; clear and clipped beats
// skip the mix step. The steps follow the read-modify-write of the canvas RAM,
// whose read data arrives in the cycle after the address. The result register
// frees the input side as soon as the result is loaded, so a stalled output holds
// only the following beat in its last step. Reset returns the controller to idle
// and the fill color to 0x000000FF; the canvas RAM is not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none
`include "rgba_layer_blend_canvas_defines.svh"
module rgba_layer_blend_canvas #(
  parameter int FRAME_COLS = rlb_pkg::DefaultWidth,
  parameter int FRAME_ROWS = rlb_pkg::DefaultHeight
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] fill_color_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [12:0] pos_x_i,
  input  wire logic [12:0] pos_y_i,
  input  wire logic [7:0]  src_red_i,
  input  wire logic [7:0]  src_green_i,
  input  wire logic [7:0]  src_blue_i,
  input  wire logic [7:0]  src_alpha_i,
  input  wire logic [7:0]  layer_alpha_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       pix_red_o,
  output logic [7:0]       pix_green_o,
  output logic [7:0]       pix_blue_o,
  output logic [7:0]       pix_alpha_o,
  output logic             clipped_o,
  output logic             skipped_o
);

  localparam int PixCount = FRAME_COLS * FRAME_ROWS;
  localparam int AddrW    = (PixCount > 1) ? $clog2(PixCount) : 1;

  rlb_pkg::state_e state_q, state_d;

  logic [31:0]     bg_q;

  // Beat held while it works through the RAM.
  rlb_pkg::req_e   kind_q;
  logic [11:0]     x_q, y_q;
  logic            clip_q;
  rlb_pkg::pix_t   src_q;
  logic [15:0]     prod_q;
  logic [7:0]      e_q;
  logic [AddrW-1:0] addr_q;
  rlb_pkg::pix_t   old_q;

  logic            accept;
  logic            clip_c;
  logic [23:0]     addr_full;
  logic [AddrW-1:0] addr_c;

  logic            ram_re, ram_we, blend_load, out_load, out_free;
  logic [31:0]     ram_rdata;
  rlb_pkg::pix_t   mix_pix;
  rlb_pkg::pix_t   res_pix;
  logic            res_skip;
  logic            res_write;

  logic            out_valid_q;
  rlb_pkg::pix_t   out_pix_q;
  logic            out_clip_q, out_skip_q;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // A position is outside when negative or at or past the canvas edge.
  assign clip_c = pos_x_i[12] || pos_y_i[12]
               || ({1'b0, pos_x_i[11:0]} >= 13'(FRAME_COLS))
               || ({1'b0, pos_y_i[11:0]} >= 13'(FRAME_ROWS));

  assign addr_full = 24'(y_q) * 24'(FRAME_COLS) + 24'(x_q);
  assign addr_c    = AddrW'(addr_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rlb_pkg::ST_IDLE;
      bg_q        <= rlb_pkg::BgReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        bg_q <= fill_color_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= rlb_pkg::req_e'(req_type_i);
      x_q    <= pos_x_i[11:0];
      y_q    <= pos_y_i[11:0];
      clip_q <= clip_c;
      src_q  <= {src_red_i, src_green_i, src_blue_i, src_alpha_i};
      prod_q <= {8'b0, src_alpha_i} * {8'b0, layer_alpha_i};
    end
    if (state_q == rlb_pkg::ST_ADDR) begin
      addr_q <= addr_c;
      e_q    <= rlb_pkg::div255(prod_q);
    end
    if (blend_load) begin
      old_q <= rlb_pkg::pix_t'(ram_rdata);
    end
    if (out_load) begin
      out_pix_q  <= res_pix;
      out_clip_q <= clip_q;
      out_skip_q <= res_skip;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rlb_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rlb_pkg::ST_ADDR;
      end
      rlb_pkg::ST_ADDR: begin
        if (clip_q || kind_q == rlb_pkg::REQ_CLEAR) state_d = rlb_pkg::ST_DONE;
        else state_d = rlb_pkg::ST_MIX;
      end
      rlb_pkg::ST_MIX: begin
        state_d = rlb_pkg::ST_DONE;
      end
      rlb_pkg::ST_DONE: begin
        if (out_free) state_d = rlb_pkg::ST_IDLE;
      end
      default: state_d = rlb_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    blend_load = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      rlb_pkg::ST_IDLE: in_stall_o = 1'b0;
      rlb_pkg::ST_ADDR: ram_re = !clip_q && kind_q != rlb_pkg::REQ_CLEAR;
      rlb_pkg::ST_MIX:  blend_load = 1'b1;
      rlb_pkg::ST_DONE: out_load = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  // Result and write-back of the finished beat.
  always_comb begin
    res_pix   = old_q;
    res_skip  = 1'b0;
    res_write = 1'b0;
    if (clip_q) begin
      res_pix = '0;
    end else begin
      unique case (kind_q)
        rlb_pkg::REQ_CLEAR: begin
          res_pix   = rlb_pkg::pix_t'(bg_q);
          res_write = 1'b1;
        end
        rlb_pkg::REQ_BLEND: begin
          if (e_q == 8'd0) begin
            res_skip = 1'b1;
          end else begin
            res_pix   = mix_pix;
            res_write = 1'b1;
          end
        end
        default: res_pix = old_q;
      endcase
    end
  end

  assign ram_we = out_load && res_write;

  rlb_ram #(
    .WIDTH(32),
    .DEPTH(PixCount)
  ) u_canvas (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (res_pix),
    .re_i    (ram_re),
    .raddr_i (addr_c),
    .rdata_o (ram_rdata)
  );

  rlb_blend u_blend (
    .clk_i  (clk_i),
    .load_i (blend_load),
    .src_i  (src_q),
    .old_i  (rlb_pkg::pix_t'(ram_rdata)),
    .e_i    (e_q),
    .mix_o  (mix_pix)
  );

  assign out_valid_o = out_valid_q;
  assign pix_red_o   = out_pix_q.r;
  assign pix_green_o = out_pix_q.g;
  assign pix_blue_o  = out_pix_q.b;
  assign pix_alpha_o = out_pix_q.a;
  assign clipped_o   = out_clip_q;
  assign skipped_o   = out_skip_q;

  `RLB_ASSERT(a_accept_to_addr, accept |=> state_q == rlb_pkg::ST_ADDR, "accepted beat did not start address phase")
  `RLB_ASSERT(a_clip_is_zero, (out_valid_o && clipped_o) |-> (out_pix_q == '0 && !skipped_o), "clipped result carries pixel data")
  `RLB_ASSERT(a_no_rw_overlap, !(ram_we && ram_re), "canvas read and write in the same cycle")
  `RLB_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == rlb_pkg::ST_DONE), "result loaded outside the final step")

endmodule
`default_nettype wire
